// File: design/fiff_pkg.sv
`default_nettype none

package fiff_pkg;

    // Default and digit limits
    localparam int MAX_WIDTH_DEF = 64;
    localparam int DIG_COUNT     = 10;
    localparam int DIG_IDX_W     = 4;

    // Field characters
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_BLANK = 8'h20;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    // Reciprocal of ten, exact for any 32-bit dividend with a shift of 35
    localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
    localparam int          RECIP_SH  = 35;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } fiff_state_t;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic emit_step;
    } fiff_cmd_t;

    typedef struct packed {
        logic conv_last;
        logic w_zero;
        logic emit_last;
        logic out_free;
    } fiff_status_t;

endpackage

`default_nettype wire

// File: design/fiff_ctrl.sv
`default_nettype none

module fiff_ctrl
    import fiff_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   s_valid,
    output logic        s_ready,
    input  wire fiff_status_t status,
    output fiff_cmd_t   cmd
);

    fiff_state_t state_reg;
    fiff_state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequence load, digit conversion and character emission
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.conv_step = 1'b1;
                if (status.conv_last) begin
                    state_next = status.w_zero ? ST_IDLE : ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit_step = 1'b1;
                    if (status.emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A finished conversion of a non-empty field goes on to emission
    a_conv_to_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.conv_step && status.conv_last && !status.w_zero) |=> (state_reg == ST_EMIT))
        else $error("conversion did not hand over to emission");

    // No request is taken while a field is still in progress
    a_busy_no_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.conv_step || cmd.emit_step) |-> !s_ready)
        else $error("input taken while busy");

endmodule

`default_nettype wire

// File: design/fiff_datapath.sv
`default_nettype none

module fiff_datapath
    import fiff_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic               cfg_force_plus,
    input  wire logic signed [31:0] s_value,
    input  wire logic               s_short_operand,
    input  wire logic        [6:0]  s_width,
    input  wire logic        [6:0]  s_min_digits,
    input  wire logic               m_ready,
    output logic                    m_valid,
    output logic             [7:0]  m_character,
    output logic                    m_last,
    input  wire fiff_cmd_t          cmd,
    output fiff_status_t            status
);

    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int CB = ((WB > 7) ? WB : 7) + 1;

    logic                 force_plus_reg;
    logic                 neg_reg;
    logic                 mag_zero_reg;
    logic [31:0]          t_reg;
    logic [3:0]           nd_reg;
    logic [3:0]           dig_reg [DIG_COUNT];
    logic [WB-1:0]        w_reg;
    logic [WB-1:0]        j_reg;
    logic [6:0]           m_reg;
    logic                 m_valid_reg;
    logic [7:0]           m_character_reg;
    logic                 m_last_reg;

    logic signed [31:0]   ext;
    logic [31:0]          mag;
    logic [WB-1:0]        w_sat;
    logic [63:0]          prod;
    logic [31:0]          quot;
    logic [3:0]           rem;
    logic                 xs;
    logic [CB-1:0]        nd_c;
    logic [CB-1:0]        m_c;
    logic [CB-1:0]        w_c;
    logic [CB-1:0]        j_c;
    logic [CB-1:0]        xs_c;
    logic [CB-1:0]        body_c;
    logic                 star;
    logic [3:0]           dsel;
    logic [7:0]           char_next;
    logic                 out_free;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            force_plus_reg <= 1'b0;
        end else if (cfg_we) begin
            force_plus_reg <= cfg_force_plus;
        end
    end

    // Sign, magnitude and saturated width of the incoming request
    always_comb begin
        ext = s_short_operand ? 32'(signed'(s_value[15:0])) : s_value;
        mag = ext[31] ? (32'd0 - 32'(ext)) : 32'(ext);
        if (32'(s_width) > 32'(MAX_WIDTH)) begin
            w_sat = WB'(MAX_WIDTH);
        end else begin
            w_sat = WB'(s_width);
        end
    end

    // Divide by ten through the reciprocal, one digit per cycle
    always_comb begin
        prod = 64'(t_reg) * 64'(RECIP_TEN);
        quot = 32'(prod[63:RECIP_SH]);
        rem  = 4'(t_reg - ((quot << 3) + (quot << 1)));
    end

    // Load the request and run the conversion
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            neg_reg      <= ext[31];
            mag_zero_reg <= (mag == 32'd0);
            t_reg        <= mag;
            nd_reg       <= '0;
            w_reg        <= w_sat;
            j_reg        <= w_sat - WB'(1);
            m_reg        <= s_min_digits;
        end else if (cmd.conv_step) begin
            dig_reg[nd_reg] <= rem;
            t_reg           <= quot;
            nd_reg          <= nd_reg + 4'd1;
        end else if (cmd.emit_step) begin
            j_reg <= j_reg - WB'(1);
        end
    end

    // Pick the character at distance j from the right-hand end
    always_comb begin
        xs     = neg_reg || force_plus_reg;
        nd_c   = CB'(nd_reg);
        m_c    = CB'(m_reg);
        w_c    = CB'(w_reg);
        j_c    = CB'(j_reg);
        xs_c   = CB'(xs);
        body_c = (nd_c >= m_c) ? nd_c : m_c;
        star   = ((nd_c + xs_c) > w_c) || ((m_c + xs_c) > w_c);
        dsel   = (j_reg[DIG_IDX_W-1:0] < 4'(DIG_COUNT)) ? dig_reg[j_reg[DIG_IDX_W-1:0]] : 4'd0;
        priority if (mag_zero_reg && (m_reg == 7'd0)) begin
            char_next = CHAR_BLANK;
        end else if (star) begin
            char_next = CHAR_STAR;
        end else if (j_c < nd_c) begin
            char_next = CHAR_ZERO + {4'd0, dsel};
        end else if (j_c < body_c) begin
            char_next = CHAR_ZERO;
        end else if ((j_c == body_c) && xs) begin
            char_next = neg_reg ? CHAR_MINUS : CHAR_PLUS;
        end else begin
            char_next = CHAR_BLANK;
        end
    end

    // Output register: hold until taken, refill on each emission step
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_step) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_step) begin
            m_character_reg <= char_next;
            m_last_reg      <= (j_reg == '0);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_character = m_character_reg;
    assign m_last      = m_last_reg;

    // Status back to the controller
    always_comb begin
        status.conv_last = (quot == 32'd0);
        status.w_zero    = (w_reg == '0);
        status.emit_last = (j_reg == '0);
        status.out_free  = out_free;
    end

    // A 32-bit magnitude never yields more than ten digits
    a_nd_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.conv_step |-> (nd_reg < 4'(DIG_COUNT)))
        else $error("digit count overrun");

    // Emission never overwrites a character that is still waiting
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_step |-> (!m_valid_reg || m_ready))
        else $error("output register overwritten");

    // The character at the right-hand end carries the last flag
    a_last_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_step && (j_reg == '0)) |=> (m_valid_reg && m_last_reg))
        else $error("last flag missing on final character");

endmodule

`default_nettype wire

// File: design/fortran_integer_field_formatter_unit.sv
// Operation: after a request is taken, its D decimal digits (1 to 10) are made one per
// divide-by-ten step, then the W characters of the field (W = saturated width) are offered.
// A new request is taken only after the current field has been converted and emitted,
// as set by the single digit unit and the one-character output register.
// Reset: aresetn is synchronous and active low; it idles the controller, empties the
// output register and clears force_plus to 0.
`default_nettype none

module fortran_integer_field_formatter_unit
    import fiff_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_force_plus,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_value,
    input  wire logic               s_short_operand,
    input  wire logic        [6:0]  s_width,
    input  wire logic        [6:0]  s_min_digits,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic             [7:0]  m_character,
    output logic                    m_last
);

    fiff_cmd_t    cmd;
    fiff_status_t status;
    logic         cfg_we;

    // Configuration is always taken
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    fiff_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    fiff_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_force_plus  (cfg_force_plus),
        .s_value         (s_value),
        .s_short_operand (s_short_operand),
        .s_width         (s_width),
        .s_min_digits    (s_min_digits),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_character     (m_character),
        .m_last          (m_last),
        .cmd             (cmd),
        .status          (status)
    );

endmodule

`default_nettype wire

// File: tb/tb_fortran_integer_field_formatter_unit.sv
`default_nettype none

module tb_fortran_integer_field_formatter_unit;
    import fiff_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int TAIL_CYCLES = 100;
    localparam int FIELD_MAX   = MAX_WIDTH_DEF;
    localparam int ROW_COUNT   = 25;
    localparam int PHASE_ITEMS = 69;

    // One character of a formatted field
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } field_char_t;

    // Directed row: when typed is set, text holds the whole field, right-aligned
    typedef struct packed {
        logic        plus;
        logic [31:0] value;
        logic        short_op;
        logic [6:0]  wid;
        logic [6:0]  mind;
        logic        typed;
        logic [87:0] text;
    } request_row_t;

    localparam request_row_t DIRECTED_ROWS [ROW_COUNT] = '{
        '{1'b0, 32'h0000_0000, 1'b0, 7'd5,   7'd0,   1'b1, "     "},
        '{1'b0, 32'h0000_0000, 1'b0, 7'd3,   7'd2,   1'b1, " 00"},
        '{1'b0, 32'h0000_0000, 1'b0, 7'd0,   7'd0,   1'b1, ""},
        '{1'b0, 32'h8000_0000, 1'b0, 7'd11,  7'd0,   1'b1, "-2147483648"},
        '{1'b0, 32'h8000_0000, 1'b0, 7'd10,  7'd0,   1'b1, "**********"},
        '{1'b0, 32'h7FFF_FFFF, 1'b0, 7'd10,  7'd0,   1'b1, "2147483647"},
        '{1'b0, 32'h0001_8000, 1'b1, 7'd6,   7'd0,   1'b1, "-32768"},
        '{1'b0, 32'hFFFF_7FFF, 1'b1, 7'd5,   7'd0,   1'b1, "32767"},
        '{1'b0, 32'hFFFF_FFFF, 1'b1, 7'd1,   7'd0,   1'b1, "*"},
        '{1'b0, 32'h0000_007B, 1'b0, 7'd2,   7'd0,   1'b1, "**"},
        '{1'b0, 32'h0000_0005, 1'b0, 7'd3,   7'd3,   1'b1, "005"},
        '{1'b0, 32'h0000_0005, 1'b0, 7'd3,   7'd4,   1'b1, "***"},
        '{1'b0, 32'hFFFF_FFF9, 1'b0, 7'd127, 7'd0,   1'b0, ""},
        '{1'b0, 32'h0000_0007, 1'b0, 7'd64,  7'd64,  1'b0, ""},
        '{1'b0, 32'h0000_002A, 1'b0, 7'd64,  7'd127, 1'b0, ""},
        '{1'b0, 32'hFFFF_FFFF, 1'b0, 7'd0,   7'd127, 1'b1, ""},
        '{1'b0, 32'h0000_0009, 1'b0, 7'd1,   7'd1,   1'b1, "9"},
        '{1'b0, 32'h8000_0000, 1'b1, 7'd4,   7'd0,   1'b1, "    "},
        '{1'b1, 32'h0000_0005, 1'b0, 7'd3,   7'd3,   1'b1, "***"},
        '{1'b1, 32'h0000_0000, 1'b0, 7'd4,   7'd0,   1'b1, "    "},
        '{1'b1, 32'h0000_0000, 1'b0, 7'd3,   7'd1,   1'b1, " +0"},
        '{1'b1, 32'h7FFF_FFFF, 1'b0, 7'd11,  7'd0,   1'b1, "+2147483647"},
        '{1'b1, 32'hFFFF_FFF6, 1'b0, 7'd6,   7'd4,   1'b1, " -0010"},
        '{1'b1, 32'hAAAA_5555, 1'b1, 7'd8,   7'd0,   1'b0, ""},
        '{1'b1, 32'h5555_AAAA, 1'b0, 7'd127, 7'd1,   1'b0, ""}
    };

    logic               aclk            = 1'b0;
    logic               aresetn         = 1'b0;
    logic               cfg_valid       = 1'b0;
    logic               cfg_ready;
    logic               cfg_force_plus  = 1'b0;
    logic               s_valid         = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_value         = '0;
    logic               s_short_operand = 1'b0;
    logic        [6:0]  s_width         = '0;
    logic        [6:0]  s_min_digits    = '0;
    logic               m_valid;
    logic               m_ready         = 1'b0;
    logic        [7:0]  m_character;
    logic               m_last;

    field_char_t expected_chars [$];
    field_char_t oldest_char;
    logic        plus_setting   = 1'b0;
    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;
    int          mismatch_count = 0;
    int          cycle_count    = 0;

    fortran_integer_field_formatter_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_force_plus  (cfg_force_plus),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_value         (s_value),
        .s_short_operand (s_short_operand),
        .s_width         (s_width),
        .s_min_digits    (s_min_digits),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_character     (m_character),
        .m_last          (m_last)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Format one Iw.m field and queue its characters
    function automatic void predict_field(input logic [31:0] raw, input logic short_op,
                                          input logic [6:0] wid, input logic [6:0] mind,
                                          input logic plus);
        logic        neg;
        logic [31:0] mag;
        logic [31:0] rest;
        logic [7:0]  digits [10];
        logic [7:0]  line [$];
        int          nd;
        int          w;
        int          m;
        int          sign_len;
        int          spare;
        int          i;
        if (short_op) begin
            neg = raw[15];
            mag = neg ? (32'h0001_0000 - {16'h0000, raw[15:0]}) : {16'h0000, raw[15:0]};
        end else begin
            neg = raw[31];
            mag = neg ? (32'd0 - raw) : raw;
        end
        w  = (int'(wid) > FIELD_MAX) ? FIELD_MAX : int'(wid);
        m  = int'(mind);
        nd = 0;
        if (mag == 32'd0 && m == 0) begin
            for (i = 0; i < w; i++) line.push_back(CHAR_BLANK);
        end else begin
            rest = mag;
            do begin
                digits[nd] = CHAR_ZERO + 8'(rest % 32'd10);
                rest       = rest / 32'd10;
                nd++;
            end while (rest != 32'd0);
            sign_len = (neg || plus) ? 1 : 0;
            if (nd + sign_len > w || m + sign_len > w) begin
                for (i = 0; i < w; i++) line.push_back(CHAR_STAR);
            end else begin
                spare = w - ((nd >= m) ? nd : m) - sign_len;
                for (i = 0; i < spare; i++) line.push_back(CHAR_BLANK);
                if (neg) line.push_back(CHAR_MINUS);
                else if (plus) line.push_back(CHAR_PLUS);
                for (i = nd; i < m; i++) line.push_back(CHAR_ZERO);
                for (i = nd; i > 0; i--) line.push_back(digits[i - 1]);
            end
        end
        for (i = 0; i < w; i++) expected_chars.push_back('{line[i], i == w - 1});
    endfunction

    // Offer one request, hold it until taken, then queue its field
    task automatic send_request(input logic [31:0] val, input logic short_op,
                                input logic [6:0] wid, input logic [6:0] mind,
                                input logic typed, input logic [87:0] text);
        int w;
        int i;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid         <= 1'b1;
        s_value         <= val;
        s_short_operand <= short_op;
        s_width         <= wid;
        s_min_digits    <= mind;
        do @(posedge aclk); while (!s_ready);
        if (typed) begin
            w = (int'(wid) > FIELD_MAX) ? FIELD_MAX : int'(wid);
            for (i = 0; i < w; i++) expected_chars.push_back('{text[8*(w-1-i) +: 8], i == w - 1});
        end else begin
            predict_field(val, short_op, wid, mind, plus_setting);
        end
    endtask

    // Hold off new requests until every queued character has arrived
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge aclk);
    endtask

    // Drain, then let a zero-width request still in flight finish
    task automatic settle_block();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic write_force_plus(input logic plus);
        settle_block();
        cfg_valid      <= 1'b1;
        cfg_force_plus <= plus;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid    <= 1'b0;
        plus_setting  = plus;
    endtask

    // Mostly plausible fields with random content, some oversize or odd ones
    task automatic send_random_item();
        logic [31:0] val;
        logic [6:0]  wid;
        logic [6:0]  mind;
        case ($urandom_range(6))
            0: val = $urandom_range(9);
            1: val = $urandom_range(99999);
            2: val = 32'd0 - $urandom_range(1000);
            3: val = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            4: val = 32'd0;
            default: val = $urandom();
        endcase
        case ($urandom_range(19))
            0: wid = 7'd0;
            1: wid = 7'($urandom_range(127, 65));
            2, 3: wid = 7'($urandom_range(64, 13));
            default: wid = 7'($urandom_range(12, 1));
        endcase
        case ($urandom_range(9))
            6, 7: mind = 7'($urandom_range(int'(wid), 0));
            8: mind = 7'($urandom_range(127));
            9: mind = 7'd0;
            default: mind = 7'($urandom_range(3));
        endcase
        send_request(val, $urandom_range(9) < 3, wid, mind, 1'b0, '0);
    endtask

    // Randomise the result side and compare each character taken
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_chars.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected character %h last %b", m_character, m_last);
            end else begin
                oldest_char = expected_chars.pop_front();
                if (oldest_char.ch !== m_character || oldest_char.last !== m_last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("character: expected %h last %b, got %h last %b",
                                 oldest_char.ch, oldest_char.last, m_character, m_last);
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Bound the run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL fortran_integer_field_formatter_unit");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table, sender idling lightly and receiver heavily
        send_idle_pct = 30;
        recv_idle_pct = 88;
        for (int r = 0; r < ROW_COUNT; r++) begin
            if (DIRECTED_ROWS[r].plus !== plus_setting)
                write_force_plus(DIRECTED_ROWS[r].plus);
            send_request(DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].short_op,
                         DIRECTED_ROWS[r].wid, DIRECTED_ROWS[r].mind,
                         DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].text);
        end

        // Random phases: same idling first, then swapped, then none
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 88 : 0;
            recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 30 : 0;
            write_force_plus((phase == 2) ? logic'($urandom_range(1)) : logic'(phase == 0));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2)
                    write_force_plus(!plus_setting);
                else if (phase == 0 && n == 20)
                    drain_results();
                send_random_item();
            end
        end

        settle_block();
        if (mismatch_count == 0 && expected_chars.size() == 0) begin
            $display("PASS fortran_integer_field_formatter_unit");
        end else begin
            $display("FAIL fortran_integer_field_formatter_unit");
        end
        $finish;
    end

endmodule

`default_nettype wire
